// ===== rtl/core/hpp_pkg.sv =====
// Shared types and constants for the homography point projection block.
package hpp_pkg;

    localparam int FRAC_BITS_DEF = 16;                 // Q16.16 by default
    localparam int WORD_W        = 32;                 // every field and register
    localparam int NREGS         = 8;                  // h22 is fixed at 1.0
    localparam int REG_IDX_W     = $clog2(NREGS);
    localparam int PROD_W        = 2 * WORD_W;         // full 32x32 product
    localparam int QB_W          = WORD_W + 1;         // quotient bits kept by the divider

    localparam int MAC_STAGES    = 3;                  // product, pair sum, row sum
    localparam int DIV_STAGES    = QB_W + 3;           // abs, range check, one per bit, clamp
    localparam int LATENCY       = MAC_STAGES + DIV_STAGES;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_H00,
        REG_H01,
        REG_H02,
        REG_H10,
        REG_H11,
        REG_H12,
        REG_H20,
        REG_H21
    } t_reg_idx;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [NREGS-1:0] t_hmat;

    typedef struct packed {
        logic valid;
        logic at_inf;
        logic sat;
    } t_res_flags;

endpackage

// ===== rtl/core/hpp_regs.sv =====
// Matrix register file, written through the plain configuration port.
module hpp_regs #(
    parameter int FRAC_BITS = hpp_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hpp_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  hpp_pkg::t_word                 i_cfg_data,
    output hpp_pkg::t_hmat                 o_h
);
    import hpp_pkg::*;

    localparam t_word ONE = t_word'(1) << FRAC_BITS;

    function automatic t_hmat h_identity();
        t_hmat m;
        m          = '0;
        m[REG_H00] = ONE;
        m[REG_H11] = ONE;
        return m;
    endfunction

    localparam t_hmat H_RESET = h_identity();

    t_hmat r_h;

    // identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= H_RESET;
        end else if (i_cfg_we) begin
            r_h[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign o_h = r_h;

endmodule

// ===== rtl/core/hpp_mac.sv =====
// Matrix-vector product: eight multipliers, then two adder stages per row.
module hpp_mac #(
    parameter int FRAC_BITS = hpp_pkg::FRAC_BITS_DEF,
    localparam int SUM_W    = hpp_pkg::PROD_W - FRAC_BITS + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  hpp_pkg::t_word          i_x,
    input  hpp_pkg::t_word          i_y,
    input  hpp_pkg::t_word          i_w,
    input  hpp_pkg::t_hmat          i_h,
    output logic                    o_valid,
    output logic signed [SUM_W-1:0] o_tx,
    output logic signed [SUM_W-1:0] o_ty,
    output logic signed [SUM_W-1:0] o_tz
);
    import hpp_pkg::*;

    localparam int SP_W = PROD_W - FRAC_BITS;   // product after the floor shift

    // stage 1: products
    logic signed [WORD_W-1:0] n1_op [NREGS];
    logic signed [PROD_W-1:0] r1_p  [NREGS];
    logic signed [WORD_W-1:0] r1_w;
    logic                     r1_vld;

    assign n1_op[REG_H00] = $signed(i_x);
    assign n1_op[REG_H01] = $signed(i_y);
    assign n1_op[REG_H02] = $signed(i_w);
    assign n1_op[REG_H10] = $signed(i_x);
    assign n1_op[REG_H11] = $signed(i_y);
    assign n1_op[REG_H12] = $signed(i_w);
    assign n1_op[REG_H20] = $signed(i_x);
    assign n1_op[REG_H21] = $signed(i_y);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NREGS; i++) begin
            r1_p[i] <= PROD_W'($signed(i_h[i])) * PROD_W'(n1_op[i]);
        end
        r1_w <= $signed(i_w);
    end

    // stage 2: arithmetic shift (floor), first add of each row
    logic signed [PROD_W-1:0] n2_shift [NREGS];
    logic signed [SP_W-1:0]   n2_sp    [NREGS];
    logic signed [SUM_W-1:0]  r2_ax, r2_ay, r2_az;
    logic signed [SP_W-1:0]   r2_bx, r2_by;
    logic signed [WORD_W-1:0] r2_bz;
    logic                     r2_vld;

    always_comb begin
        for (int i = 0; i < NREGS; i++) begin
            n2_shift[i] = r1_p[i] >>> FRAC_BITS;
            n2_sp[i]    = $signed(n2_shift[i][SP_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r2_ax <= SUM_W'(n2_sp[REG_H00]) + SUM_W'(n2_sp[REG_H01]);
        r2_bx <= n2_sp[REG_H02];
        r2_ay <= SUM_W'(n2_sp[REG_H10]) + SUM_W'(n2_sp[REG_H11]);
        r2_by <= n2_sp[REG_H12];
        r2_az <= SUM_W'(n2_sp[REG_H20]) + SUM_W'(n2_sp[REG_H21]);
        r2_bz <= r1_w;                              // h22 is exactly 1.0
    end

    // stage 3: row sums, exact
    always_ff @(posedge i_clk) begin
        o_tx <= r2_ax + SUM_W'(r2_bx);
        o_ty <= r2_ay + SUM_W'(r2_by);
        o_tz <= r2_az + SUM_W'(r2_bz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r1_vld  <= i_valid;
            r2_vld  <= r1_vld;
            o_valid <= r2_vld;
        end
    end

endmodule

// ===== rtl/core/hpp_div.sv =====
// Two-lane pipelined restoring divider with a shared denominator, one quotient bit per stage.
module hpp_div #(
    parameter int FRAC_BITS = hpp_pkg::FRAC_BITS_DEF,
    localparam int SUM_W    = hpp_pkg::PROD_W - FRAC_BITS + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [SUM_W-1:0] i_num_x,
    input  logic signed [SUM_W-1:0] i_num_y,
    input  logic signed [SUM_W-1:0] i_den,
    output hpp_pkg::t_res_flags     o_flags,
    output hpp_pkg::t_word          o_qx,
    output hpp_pkg::t_word          o_qy
);
    import hpp_pkg::*;

    localparam int MAG_W = SUM_W - 1;          // |row sum| < 2^(64-F)
    localparam int SH    = QB_W - FRAC_BITS;   // numerator bits above quotient bit 32
    localparam int NL    = 2;
    localparam int NST   = QB_W + 1;
    localparam logic [QB_W-1:0] LIM_NEG = QB_W'(1) << (WORD_W - 1);
    localparam logic [QB_W-1:0] LIM_POS = LIM_NEG - QB_W'(1);

    function automatic logic [MAG_W-1:0] abs_mag(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] a;
        a = v[SUM_W-1] ? -v : v;
        return a[MAG_W-1:0];
    endfunction

    // stage A: magnitudes and signs
    logic signed [SUM_W-1:0] n_num [NL];
    logic                    r0_vld;
    logic                    r0_zero;
    logic [MAG_W-1:0]        r0_dmag;
    logic [MAG_W-1:0]        r0_nmag [NL];
    logic                    r0_neg  [NL];

    assign n_num[0] = i_num_x;
    assign n_num[1] = i_num_y;

    always_ff @(posedge i_clk) begin
        r0_dmag <= abs_mag(i_den);
        r0_zero <= (i_den == '0);
        for (int l = 0; l < NL; l++) begin
            r0_nmag[l] <= abs_mag(n_num[l]);
            r0_neg[l]  <= n_num[l][SUM_W-1] ^ i_den[SUM_W-1];
        end
    end

    // per-stage pipeline registers; index 0 is the range-check stage
    logic             r_vld  [NST];
    logic             r_zero [NST];
    logic [MAG_W-1:0] r_dmag [NST];
    logic [MAG_W-1:0] r_nmag [NL][NST];
    logic             r_neg  [NL][NST];
    logic             r_ovf  [NL][NST];
    logic [MAG_W-1:0] r_rem  [NL][NST];
    logic [QB_W-1:0]  r_q    [NL][NST];

    // stage B: a quotient of 2^33 or more always clamps
    logic [MAG_W-1:0] n_hi  [NL];
    logic             n_ovf [NL];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            n_hi[l]  = r0_nmag[l] >> SH;
            n_ovf[l] = (n_hi[l] >= r0_dmag);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dmag[0] <= r0_dmag;
        r_zero[0] <= r0_zero;
        for (int l = 0; l < NL; l++) begin
            r_nmag[l][0] <= r0_nmag[l];
            r_neg[l][0]  <= r0_neg[l];
            r_ovf[l][0]  <= n_ovf[l];
            r_rem[l][0]  <= n_ovf[l] ? '0 : n_hi[l];
            r_q[l][0]    <= '0;
        end
    end

    // bit stages: stage j resolves quotient bit QB_W-1-j
    for (genvar j = 0; j < QB_W; j++) begin : g_stage
        localparam int K = QB_W - 1 - j;

        always_ff @(posedge i_clk) begin
            r_dmag[j+1] <= r_dmag[j];
            r_zero[j+1] <= r_zero[j];
        end

        for (genvar l = 0; l < NL; l++) begin : g_lane
            logic             n_bit;
            logic [MAG_W:0]   n_trial;
            logic [MAG_W:0]   n_diff;
            logic             n_ge;

            if (K >= FRAC_BITS) begin : g_num_bit
                assign n_bit = r_nmag[l][j][K-FRAC_BITS];
            end else begin : g_frac_bit
                assign n_bit = 1'b0;                 // shifted-in fraction zeros
            end

            assign n_trial = {r_rem[l][j], n_bit};
            assign n_diff  = n_trial - {1'b0, r_dmag[j]};
            assign n_ge    = (n_trial >= {1'b0, r_dmag[j]});

            always_ff @(posedge i_clk) begin
                r_nmag[l][j+1] <= r_nmag[l][j];
                r_neg[l][j+1]  <= r_neg[l][j];
                r_ovf[l][j+1]  <= r_ovf[l][j];
                r_rem[l][j+1]  <= n_ge ? n_diff[MAG_W-1:0] : n_trial[MAG_W-1:0];
                r_q[l][j+1]    <= {r_q[l][j][QB_W-2:0], n_ge};
            end
        end
    end

    // final stage: clamp, restore sign
    logic [QB_W-1:0] n_lim [NL];
    logic            n_sat [NL];
    logic [QB_W-1:0] n_mag [NL];
    logic [QB_W-1:0] n_val [NL];
    logic            r_out_vld;
    logic            r_out_inf;
    logic            r_out_sat;
    t_word           r_out [NL];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            n_lim[l] = r_neg[l][QB_W] ? LIM_NEG : LIM_POS;
            n_sat[l] = r_ovf[l][QB_W] || (r_q[l][QB_W] > n_lim[l]);
            n_mag[l] = n_sat[l] ? n_lim[l] : r_q[l][QB_W];
            n_val[l] = r_neg[l][QB_W] ? (QB_W'(0) - n_mag[l]) : n_mag[l];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_inf <= r_zero[QB_W];
        r_out_sat <= !r_zero[QB_W] && (n_sat[0] || n_sat[1]);
        for (int l = 0; l < NL; l++) begin
            r_out[l] <= r_zero[QB_W] ? '0 : n_val[l][WORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld    <= 1'b0;
            r_vld[0]  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r0_vld    <= i_valid;
            r_vld[0]  <= r0_vld;
            r_out_vld <= r_vld[QB_W];
        end
    end

    for (genvar j = 0; j < QB_W; j++) begin : g_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else begin
                r_vld[j+1] <= r_vld[j];
            end
        end
    end

    assign o_flags = '{valid: r_out_vld, at_inf: r_out_inf, sat: r_out_sat};
    assign o_qx    = r_out[0];
    assign o_qy    = r_out[1];

endmodule

// ===== rtl/core/homography_point_projection.sv =====
// Top level: homography projection of a homogeneous point, fully pipelined.
//
// Usage
//   Input: drive i_in_x, i_in_y, i_in_w (signed fixed point, FRAC_BITS fraction
//   bits) with start high. A point is taken at each rising edge where start is
//   high and busy is low. busy is high only during reset and in the first cycle
//   after it; otherwise a new point may be given in every cycle.
//   Output: each result is shown for exactly one cycle with o_valid high, in the
//   order the points went in. The receiver cannot hold results off, and the
//   block never needs to: every stage advances each cycle.
//   Throughput: one point per cycle. A result passes through the three
//   multiply/add stages, then the divider: the abs and range-check stages,
//   33 stages with one quotient bit each, and the clamp stage.
//   Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write one matrix entry per
//   cycle (h00 h01 h02 h10 h11 h12 h20 h21; h22 is 1.0). Write only while no
//   point is in flight.
//   Reset: synchronous, active low; the matrix returns to identity and every
//   in-flight point is dropped.
//   Z == 0 gives o_at_infinity with zero coordinates; a quotient outside the
//   32-bit range is clamped and flagged on o_saturated.
module homography_point_projection #(
    parameter int FRAC_BITS = hpp_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [hpp_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  hpp_pkg::t_word                i_cfg_data,
    input  hpp_pkg::t_word                i_in_x,
    input  hpp_pkg::t_word                i_in_y,
    input  hpp_pkg::t_word                i_in_w,
    output logic                          o_valid,
    output hpp_pkg::t_word                o_out_x,
    output hpp_pkg::t_word                o_out_y,
    output logic                          o_at_infinity,
    output logic                          o_saturated
);
    import hpp_pkg::*;

    localparam int SUM_W = PROD_W - FRAC_BITS + 1;

    // busy covers reset and the cycle right after it
    logic r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy || !i_rst_n;

    logic n_accept;
    assign n_accept = start && !busy;

    t_hmat w_h;

    hpp_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_h        (w_h)
    );

    // row sums X, Y, Z, exact
    logic                    w_mac_vld;
    logic signed [SUM_W-1:0] w_tx, w_ty, w_tz;

    hpp_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n_accept),
        .i_x     (i_in_x),
        .i_y     (i_in_y),
        .i_w     (i_in_w),
        .i_h     (w_h),
        .o_valid (w_mac_vld),
        .o_tx    (w_tx),
        .o_ty    (w_ty),
        .o_tz    (w_tz)
    );

    // X/Z and Y/Z, truncated toward zero, with clamp and flags
    t_res_flags w_flags;

    hpp_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mac_vld),
        .i_num_x (w_tx),
        .i_num_y (w_ty),
        .i_den   (w_tz),
        .o_flags (w_flags),
        .o_qx    (o_out_x),
        .o_qy    (o_out_y)
    );

    assign o_valid       = w_flags.valid;
    assign o_at_infinity = w_flags.at_inf;
    assign o_saturated   = w_flags.sat;

endmodule

// ===== rtl/core/hpp_checker.sv =====
// Port-level checks for the projection block, bound to the top level.
module hpp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input hpp_pkg::t_word                o_out_x,
    input hpp_pkg::t_word                o_out_y,
    input logic                          o_at_infinity,
    input logic                          o_saturated
);
    import hpp_pkg::*;

    // a result only ever comes out for an earlier accepted transfer in
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_rst_n, LATENCY))
        else $error("result without a matching input transfer");

    a_infinity_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_at_infinity) |-> (o_out_x == '0 && o_out_y == '0 && !o_saturated))
        else $error("point at infinity with nonzero outputs or saturation");

    a_sat_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_out_x == 32'h7FFF_FFFF || o_out_x == 32'h8000_0000 ||
             o_out_y == 32'h7FFF_FFFF || o_out_y == 32'h8000_0000))
        else $error("saturation flagged but no output at a bound");

    a_busy_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> busy)
        else $error("input taken in the cycle right after reset");

endmodule

bind homography_point_projection hpp_checker u_hpp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_out_x       (o_out_x),
    .o_out_y       (o_out_y),
    .o_at_infinity (o_at_infinity),
    .o_saturated   (o_saturated)
);
